// ===== hdl/lppk_pkg.sv =====
// shared types, codes and rate function for the predator-prey lattice step
`timescale 1ns / 1ps
package lppk_pkg;

  // storage geometry
  localparam int unsigned CELL_DEPTH = 4096;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned RATE_DEPTH = 5 * CELL_DEPTH;
  localparam int unsigned RADDR_W    = 15;
  localparam int unsigned NUM_RX     = 5;
  localparam int unsigned ALU_W      = 34;

  // grid limits
  localparam logic [6:0] GRID_MIN = 7'd3;
  localparam logic [6:0] GRID_MAX = 7'd64;

  // operation codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_INIT = 2'd1;
  localparam logic [1:0] OP_STEP = 2'd2;

  // cell states
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_PREY  = 2'd1;
  localparam logic [1:0] ST_PRED  = 2'd2;

  // reaction kinds
  localparam logic [2:0] RX_PREY_BIRTH  = 3'd0;
  localparam logic [2:0] RX_PREY_DEATH  = 3'd1;
  localparam logic [2:0] RX_PREY_EATEN  = 3'd2;
  localparam logic [2:0] RX_PRED_BIRTH  = 3'd3;
  localparam logic [2:0] RX_PRED_DEATH  = 3'd4;

  // neighbor selects
  localparam logic [2:0] SEL_SELF  = 3'd0;
  localparam logic [2:0] SEL_UP    = 3'd1;
  localparam logic [2:0] SEL_RIGHT = 3'd2;
  localparam logic [2:0] SEL_DOWN  = 3'd3;
  localparam logic [2:0] SEL_LEFT  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PREY_BIRTH  = 3'd2;
  localparam logic [2:0] REG_PREY_DEATH  = 3'd3;
  localparam logic [2:0] REG_PREY_EATEN  = 3'd4;
  localparam logic [2:0] REG_PRED_BIRTH  = 3'd5;
  localparam logic [2:0] REG_PRED_DEATH  = 3'd6;

  typedef struct packed {
    logic [12:0] prey_birth;
    logic [12:0] prey_death;
    logic [12:0] prey_eaten;
    logic [12:0] pred_birth;
    logic [12:0] pred_death;
  } rate_cfg_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  // state a cell takes after each reaction kind
  function automatic logic [1:0] result_state(logic [2:0] kind);
    logic [1:0] s;
    case (kind)
      RX_PREY_BIRTH: s = ST_PREY;
      RX_PRED_BIRTH: s = ST_PRED;
      default:       s = ST_EMPTY;
    endcase
    return s;
  endfunction

  // one reaction rate of a cell from its state and neighbor counts
  function automatic logic [15:0] rate_calc(logic [2:0] kind, logic [1:0] ctr,
                                            logic [2:0] np, logic [2:0] nd,
                                            rate_cfg_t rc);
    logic [15:0] r;
    logic        is_prey;
    logic        is_pred;
    r       = '0;
    is_prey = (ctr == ST_PREY);
    is_pred = (ctr == ST_PRED);
    case (kind)
      RX_PREY_BIRTH: if (!is_prey && !is_pred) r = 16'(np) * 16'(rc.prey_birth);
      RX_PREY_DEATH: if (is_prey) r = 16'(rc.prey_death);
      RX_PREY_EATEN: if (is_prey) r = 16'(nd) * 16'(rc.prey_eaten);
      RX_PRED_BIRTH: if (is_prey) r = 16'(nd) * 16'(rc.pred_birth);
      RX_PRED_DEATH: if (is_pred) r = 16'(rc.pred_death);
      default:       r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/lppk_alu.sv =====
// shared add/subtract unit used by the remainder, scan, rate-sum and total steps of the sequencer
`timescale 1ns / 1ps
module lppk_alu import lppk_pkg::*; (
  input  alu_req_t         req_i,
  output logic [ALU_W-1:0] res_o,
  output logic             neg_o
);

  // single adder, b inverted for subtraction
  always_comb begin
    if (req_i.sub) begin
      res_o = req_i.a - req_i.b;
    end else begin
      res_o = req_i.a + req_i.b;
    end
    neg_o = res_o[ALU_W-1];
  end

endmodule

// ===== hdl/lppk_nbr.sv =====
// wrapped neighbor coordinates and linear index on the torus
`timescale 1ns / 1ps
module lppk_nbr import lppk_pkg::*; (
  input  logic [5:0]       row_i,
  input  logic [5:0]       col_i,
  input  logic [2:0]       sel_i,
  input  logic [6:0]       width_i,
  input  logic [6:0]       height_i,
  output logic [5:0]       row_o,
  output logic [5:0]       col_o,
  output logic [IDX_W-1:0] idx_o
);

  logic [6:0]  wm1;
  logic [6:0]  hm1;
  logic [12:0] lin;

  assign wm1 = width_i - 7'd1;
  assign hm1 = height_i - 7'd1;

  // wrap at the torus edges
  always_comb begin
    row_o = row_i;
    col_o = col_i;
    case (sel_i)
      SEL_UP:    row_o = (row_i == 6'd0) ? hm1[5:0] : row_i - 6'd1;
      SEL_RIGHT: col_o = ({1'b0, col_i} == wm1) ? 6'd0 : col_i + 6'd1;
      SEL_DOWN:  row_o = ({1'b0, row_i} == hm1) ? 6'd0 : row_i + 6'd1;
      SEL_LEFT:  col_o = (col_i == 6'd0) ? wm1[5:0] : col_i - 6'd1;
      default: begin
        row_o = row_i;
        col_o = col_i;
      end
    endcase
  end

  // row times width plus column
  assign lin   = 13'(row_o) * 13'(width_i) + 13'(col_o);
  assign idx_o = lin[IDX_W-1:0];

endmodule

// ===== hdl/lattice_predator_prey_kmc_step.sv =====
// Kinetic Monte Carlo step on a toroidal predator-prey grid. One operation at
// a time; the block stalls its input until the result moves into the output
// register. An init visits each cell in use: each cell reads its own and four
// neighbor states through the single cell-store port, then writes five rates
// through the single rate-store port. A step takes the bit-serial remainder
// of the draw by the total rate, a type scan, a cell scan over up to
// width x height cells, then retires and recomputes the rates of the five
// touched cells, all on one shared add/subtract unit. Stores are not cleared
// at reset: every cell in use must be loaded before an init.
`timescale 1ns / 1ps
module lattice_predator_prey_kmc_step import lppk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [12:0]       cfg_data_i,
  // input transactions
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [IDX_W-1:0]  cell_index_i,
  input  logic [1:0]        cell_value_i,
  input  logic [30:0]       random_draw_i,
  // result transactions
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  chosen_cell_o,
  output logic [2:0]        reaction_kind_o,
  output logic [1:0]        new_state_o,
  output logic [31:0]       rate_total_o,
  output logic              no_reaction_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_MOD    = 11'b00000000010,
    S_TSCAN  = 11'b00000000100,
    S_CSCAN0 = 11'b00000001000,
    S_CSCAN  = 11'b00000010000,
    S_RM     = 11'b00000100000,
    S_STW    = 11'b00001000000,
    S_SETUP  = 11'b00010000000,
    S_SRRD   = 11'b00100000000,
    S_SRWR   = 11'b01000000000,
    S_TOT    = 11'b10000000000
  } state_e;

  // the done state shares no encoding slot; handled as its own flag
  state_e state_q, state_d;
  logic   done_q, done_d;

  // configuration
  logic [6:0] width_q, height_q;
  rate_cfg_t  rcfg_q;
  logic [6:0] w_c, h_c;
  logic [12:0] n_c;

  // working registers
  logic [30:0]      draw_q, draw_d;
  logic [31:0]      rem_q, rem_d;
  logic [4:0]       bit_q, bit_d;
  logic [2:0]       t_q, t_d;
  logic [5:0]       cur_row_q, cur_row_d, cur_col_q, cur_col_d;
  logic [IDX_W-1:0] cur_idx_q, cur_idx_d;
  logic [5:0]       tgt_row_q, tgt_row_d, tgt_col_q, tgt_col_d;
  logic [IDX_W-1:0] tgt_idx_q, tgt_idx_d;
  logic [2:0]       j_q, j_d, k_q, k_d, rd_q, rd_d;
  logic [1:0]       st_q [NUM_RX];
  logic [1:0]       st_d [NUM_RX];
  logic             pend_q, pend_d;
  logic [2:0]       pend_k_q, pend_k_d;
  logic             is_init_q, is_init_d;
  logic [31:0]      sums_q [NUM_RX];
  logic [31:0]      sums_d [NUM_RX];
  logic [31:0]      total_q, total_d;

  // pending result and output register
  logic [IDX_W-1:0] res_cell_q, res_cell_d;
  logic [2:0]       res_kind_q, res_kind_d;
  logic [1:0]       res_state_q, res_state_d;
  logic [31:0]      res_total_q, res_total_d;
  logic             res_none_q, res_none_d;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_cell_q, out_cell_d;
  logic [2:0]       out_kind_q, out_kind_d;
  logic [1:0]       out_state_q, out_state_d;
  logic [31:0]      out_total_q, out_total_d;
  logic             out_none_q, out_none_d;

  // memories and their ports
  logic [1:0]         cell_mem [CELL_DEPTH];
  logic [15:0]        rate_mem [RATE_DEPTH];
  logic               cell_we;
  logic [IDX_W-1:0]   cell_waddr, cell_raddr;
  logic [1:0]         cell_wdata, cell_rdata;
  logic               rate_we;
  logic [RADDR_W-1:0] rate_waddr, rate_raddr;
  logic [15:0]        rate_wdata, rate_rdata;

  // shared unit and neighbor units
  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_res;
  logic             alu_neg;
  logic [5:0]       na_row, na_col, nb_row, nb_col;
  logic [IDX_W-1:0] na_idx, nb_idx;

  logic       in_acc;
  logic [1:0] load_val;
  logic [2:0] np_c, nd_c;
  logic [15:0] rate_c;
  logic [32:0] cand;
  logic        cur_last, tgt_last;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE) || done_q;
  assign in_acc      = in_valid_i && !in_stall_o;

  // clamp the grid to its legal range
  always_comb begin
    w_c = (width_q < GRID_MIN) ? GRID_MIN : ((width_q > GRID_MAX) ? GRID_MAX : width_q);
    h_c = (height_q < GRID_MIN) ? GRID_MIN : ((height_q > GRID_MAX) ? GRID_MAX : height_q);
    n_c = 13'(w_c) * 13'(h_c);
  end

  assign cur_last = ({1'b0, cur_idx_q} == (n_c - 13'd1));
  assign tgt_last = ({1'b0, tgt_idx_q} == (n_c - 13'd1));
  assign load_val = (cell_value_i == 2'd3) ? ST_EMPTY : cell_value_i;
  assign cand     = {rem_q, draw_q[bit_q]};

  lppk_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res),
    .neg_o (alu_neg)
  );

  // neighbors of the chosen cell
  lppk_nbr u_nbr_a (
    .row_i    (cur_row_q),
    .col_i    (cur_col_q),
    .sel_i    (j_q),
    .width_i  (w_c),
    .height_i (h_c),
    .row_o    (na_row),
    .col_o    (na_col),
    .idx_o    (na_idx)
  );

  // neighbors of the cell whose rates are being set
  lppk_nbr u_nbr_b (
    .row_i    (tgt_row_q),
    .col_i    (tgt_col_q),
    .sel_i    (rd_q),
    .width_i  (w_c),
    .height_i (h_c),
    .row_o    (nb_row),
    .col_o    (nb_col),
    .idx_o    (nb_idx)
  );

  // neighbor counts and one rate of the target cell
  always_comb begin
    np_c = '0;
    nd_c = '0;
    for (int i = 1; i < NUM_RX; i++) begin
      np_c = np_c + 3'(st_q[i] == ST_PREY);
      nd_c = nd_c + 3'(st_q[i] == ST_PRED);
    end
    rate_c = rate_calc(k_q, st_q[0], np_c, nd_c, rcfg_q);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    draw_d      = draw_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    t_d         = t_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    cur_idx_d   = cur_idx_q;
    tgt_row_d   = tgt_row_q;
    tgt_col_d   = tgt_col_q;
    tgt_idx_d   = tgt_idx_q;
    j_d         = j_q;
    k_d         = k_q;
    rd_d        = rd_q;
    st_d        = st_q;
    pend_d      = 1'b0;
    pend_k_d    = k_q;
    is_init_d   = is_init_q;
    sums_d      = sums_q;
    total_d     = total_q;
    res_cell_d  = res_cell_q;
    res_kind_d  = res_kind_q;
    res_state_d = res_state_q;
    res_total_d = res_total_q;
    res_none_d  = res_none_q;
    alu_req     = '0;
    cell_we     = 1'b0;
    cell_waddr  = cell_index_i;
    cell_wdata  = load_val;
    cell_raddr  = nb_idx;
    rate_we     = 1'b0;
    rate_waddr  = {k_q, tgt_idx_q};
    rate_wdata  = rate_c;
    rate_raddr  = {k_q, na_idx};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          draw_d      = random_draw_i;
          res_cell_d  = '0;
          res_kind_d  = RX_PREY_BIRTH;
          res_state_d = ST_EMPTY;
          res_total_d = total_q;
          res_none_d  = 1'b0;
          case (op_i)
            OP_LOAD: begin
              cell_we     = 1'b1;
              res_cell_d  = cell_index_i;
              res_state_d = load_val;
              done_d      = 1'b1;
            end
            OP_INIT: begin
              for (int i = 0; i < NUM_RX; i++) sums_d[i] = '0;
              tgt_row_d = '0;
              tgt_col_d = '0;
              tgt_idx_d = '0;
              rd_d      = '0;
              is_init_d = 1'b1;
              state_d   = S_SRRD;
            end
            OP_STEP: begin
              if (total_q == '0) begin
                res_none_d = 1'b1;
                done_d     = 1'b1;
              end else begin
                rem_d     = '0;
                bit_d     = 5'd30;
                is_init_d = 1'b0;
                state_d   = S_MOD;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end

      // restoring remainder, one draw bit per cycle
      S_MOD: begin
        alu_req = '{sub: 1'b1, a: {1'b0, cand}, b: {2'b00, total_q}};
        rem_d   = alu_neg ? cand[31:0] : alu_res[31:0];
        if (bit_q == 5'd0) begin
          t_d     = RX_PREY_BIRTH;
          state_d = S_TSCAN;
        end else begin
          bit_d = bit_q - 5'd1;
        end
      end

      // remaining draw against the type sums
      S_TSCAN: begin
        alu_req = '{sub: 1'b1, a: {2'b00, rem_q}, b: {2'b00, sums_q[t_q]}};
        if (t_q == RX_PRED_DEATH || alu_neg) begin
          state_d = S_CSCAN0;
        end else begin
          rem_d = alu_res[31:0];
          t_d   = t_q + 3'd1;
        end
      end

      S_CSCAN0: begin
        rate_raddr = {t_q, {IDX_W{1'b0}}};
        cur_row_d  = '0;
        cur_col_d  = '0;
        cur_idx_d  = '0;
        state_d    = S_CSCAN;
      end

      // remaining draw against cell rates, next read in flight
      S_CSCAN: begin
        rate_raddr = {t_q, cur_idx_q + 12'd1};
        alu_req    = '{sub: 1'b1, a: {2'b00, rem_q}, b: {18'd0, rate_rdata}};
        if (alu_neg || cur_last) begin
          j_d     = SEL_SELF;
          k_d     = '0;
          state_d = S_RM;
        end else begin
          rem_d     = alu_res[31:0];
          cur_idx_d = cur_idx_q + 12'd1;
          if ({1'b0, cur_col_q} == w_c - 7'd1) begin
            cur_col_d = '0;
            cur_row_d = cur_row_q + 6'd1;
          end else begin
            cur_col_d = cur_col_q + 6'd1;
          end
        end
      end

      // retire old rates of the chosen cell and its neighbors
      S_RM: begin
        rate_raddr = {k_q, na_idx};
        if (pend_q) begin
          alu_req = '{sub: 1'b1, a: {2'b00, sums_q[pend_k_q]}, b: {18'd0, rate_rdata}};
          sums_d[pend_k_q] = alu_res[31:0];
        end
        if (j_q <= SEL_LEFT) begin
          pend_d   = 1'b1;
          pend_k_d = k_q;
          if (k_q == RX_PRED_DEATH) begin
            k_d = '0;
            j_d = j_q + 3'd1;
          end else begin
            k_d = k_q + 3'd1;
          end
        end else if (!pend_q) begin
          state_d = S_STW;
        end
      end

      S_STW: begin
        cell_we    = 1'b1;
        cell_waddr = cur_idx_q;
        cell_wdata = result_state(t_q);
        j_d        = SEL_SELF;
        state_d    = S_SETUP;
      end

      S_SETUP: begin
        tgt_row_d = na_row;
        tgt_col_d = na_col;
        tgt_idx_d = na_idx;
        rd_d      = '0;
        state_d   = S_SRRD;
      end

      // gather the target and its four neighbor states
      S_SRRD: begin
        cell_raddr = nb_idx;
        if (rd_q != 3'd0) st_d[rd_q - 3'd1] = cell_rdata;
        if (rd_q == 3'd5) begin
          k_d     = '0;
          state_d = S_SRWR;
        end else begin
          rd_d = rd_q + 3'd1;
        end
      end

      // write five rates and add them to the type sums
      S_SRWR: begin
        rate_we    = 1'b1;
        alu_req    = '{sub: 1'b0, a: {2'b00, sums_q[k_q]}, b: {18'd0, rate_c}};
        sums_d[k_q] = alu_res[31:0];
        if (k_q == RX_PRED_DEATH) begin
          k_d  = '0;
          rd_d = '0;
          if (is_init_q) begin
            if (tgt_last) begin
              state_d = S_TOT;
            end else begin
              state_d   = S_SRRD;
              tgt_idx_d = tgt_idx_q + 12'd1;
              if ({1'b0, tgt_col_q} == w_c - 7'd1) begin
                tgt_col_d = '0;
                tgt_row_d = tgt_row_q + 6'd1;
              end else begin
                tgt_col_d = tgt_col_q + 6'd1;
              end
            end
          end else if (j_q == SEL_LEFT) begin
            state_d = S_TOT;
          end else begin
            j_d     = j_q + 3'd1;
            state_d = S_SETUP;
          end
        end else begin
          k_d = k_q + 3'd1;
        end
      end

      // total of the type sums
      S_TOT: begin
        alu_req = '{sub: 1'b0, a: (k_q == '0) ? '0 : {2'b00, total_q},
                    b: {2'b00, sums_q[k_q]}};
        total_d = alu_res[31:0];
        if (k_q == RX_PRED_DEATH) begin
          res_total_d = alu_res[31:0];
          res_none_d  = 1'b0;
          res_cell_d  = is_init_q ? '0 : cur_idx_q;
          res_kind_d  = is_init_q ? RX_PREY_BIRTH : t_q;
          res_state_d = is_init_q ? ST_EMPTY : result_state(t_q);
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end else begin
          k_d = k_q + 3'd1;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_cell_d  = out_cell_q;
    out_kind_d  = out_kind_q;
    out_state_d = out_state_q;
    out_total_d = out_total_q;
    out_none_d  = out_none_q;
    if (done_q && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
      out_cell_d  = res_cell_q;
      out_kind_d  = res_kind_q;
      out_state_d = res_state_q;
      out_total_d = res_total_q;
      out_none_d  = res_none_q;
    end
  end

  // clear the done flag once the result moves out
  logic done_nx;
  assign done_nx = (done_q && (!out_valid_q || !out_stall_i)) ? 1'b0 : done_d;

  // control and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      width_q     <= GRID_MAX;
      height_q    <= GRID_MAX;
      rcfg_q      <= '{prey_birth: 13'd1, prey_death: 13'd1, prey_eaten: 13'd1,
                       pred_birth: 13'd1, pred_death: 13'd1};
      for (int i = 0; i < NUM_RX; i++) sums_q[i] <= '0;
      total_q     <= '0;
      bit_q       <= '0;
      t_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rd_q        <= '0;
      pend_q      <= 1'b0;
      pend_k_q    <= '0;
      is_init_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_nx;
      out_valid_q <= out_valid_d;
      sums_q      <= sums_d;
      total_q     <= total_d;
      bit_q       <= bit_d;
      t_q         <= t_d;
      j_q         <= j_d;
      k_q         <= k_d;
      rd_q        <= rd_d;
      pend_q      <= pend_d;
      pend_k_q    <= pend_k_d;
      is_init_q   <= is_init_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_GRID_WIDTH:  width_q           <= cfg_data_i[6:0];
          REG_GRID_HEIGHT: height_q          <= cfg_data_i[6:0];
          REG_PREY_BIRTH:  rcfg_q.prey_birth <= cfg_data_i;
          REG_PREY_DEATH:  rcfg_q.prey_death <= cfg_data_i;
          REG_PREY_EATEN:  rcfg_q.prey_eaten <= cfg_data_i;
          REG_PRED_BIRTH:  rcfg_q.pred_birth <= cfg_data_i;
          REG_PRED_DEATH:  rcfg_q.pred_death <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    draw_q      <= draw_d;
    rem_q       <= rem_d;
    cur_row_q   <= cur_row_d;
    cur_col_q   <= cur_col_d;
    cur_idx_q   <= cur_idx_d;
    tgt_row_q   <= tgt_row_d;
    tgt_col_q   <= tgt_col_d;
    tgt_idx_q   <= tgt_idx_d;
    st_q        <= st_d;
    res_cell_q  <= res_cell_d;
    res_kind_q  <= res_kind_d;
    res_state_q <= res_state_d;
    res_total_q <= res_total_d;
    res_none_q  <= res_none_d;
    out_cell_q  <= out_cell_d;
    out_kind_q  <= out_kind_d;
    out_state_q <= out_state_d;
    out_total_q <= out_total_d;
    out_none_q  <= out_none_d;
  end

  // cell state store
  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_rdata <= cell_mem[cell_raddr];
  end

  // reaction rate store, five rows of cells
  always_ff @(posedge clk_i) begin
    if (rate_we) rate_mem[rate_waddr] <= rate_wdata;
    rate_rdata <= rate_mem[rate_raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_cell_o   = out_cell_q;
  assign reaction_kind_o = out_kind_q;
  assign new_state_o     = out_state_q;
  assign rate_total_o    = out_total_q;
  assign no_reaction_o   = out_none_q;

endmodule
